// ===== src/sem_pkg.sv =====
// Shared types and constants of the serial EEPROM port.
package sem_pkg;

    localparam int WORDS   = 64;
    localparam int WORD_AW = $clog2(WORDS);
    localparam int WORD_W  = 16;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int CMD_W   = 8;
    localparam int CNT_W   = 5;
    localparam int LINE_W  = 4;

    localparam logic [ADDR_W-1:0] ADDR_STATUS    = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_CTRL      = 16'hFFFC;
    localparam logic [ADDR_W-1:0] ADDR_DIRECT_LO = 16'h8008;
    localparam logic [ADDR_W-1:0] ADDR_DIRECT_HI = 16'h8088;

    localparam logic [WORD_W-1:0] ERASED_WORD = 16'hFFFF;

    localparam int CTRL_INIT_BIT = 7;
    localparam int CTRL_EN_BIT   = 3;

    // serial line bits
    localparam int LN_DI  = 0;
    localparam int LN_CLK = 1;
    localparam int LN_CS  = 2;
    localparam int LN_DO  = 3;
    localparam logic [LINE_W-1:0] LINE_RESET = 4'b1000;

    localparam logic [CNT_W-1:0] OPC_BITS  = 5'd8;
    localparam logic [CNT_W-1:0] WORD_BITS = 5'd16;

    // opcode field, command bits 7:6
    localparam logic [1:0] OPC_EXT   = 2'b00;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_ERASE = 2'b11;

    // extended opcode field, command bits 5:4
    localparam logic [1:0] EXT_EWDS = 2'b00;
    localparam logic [1:0] EXT_WRAL = 2'b01;
    localparam logic [1:0] EXT_ERAL = 2'b10;
    localparam logic [1:0] EXT_EWEN = 2'b11;

    typedef enum logic [3:0] {
        PH_START  = 4'b0001,
        PH_OPCODE = 4'b0010,
        PH_READ   = 4'b0100,
        PH_WRITE  = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic slot_free;
    } t_dp_status;

endpackage

// ===== src/sem_in_if.sv =====
// Bus access channel: one CPU read or write per transaction.
interface sem_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [sem_pkg::ADDR_W-1:0]    address;
    logic [sem_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

// ===== src/sem_out_if.sv =====
// Result channel: read byte and claim flag of one bus access.
interface sem_out_if;
    logic                          valid;
    logic                          ready;
    logic [sem_pkg::DATA_W-1:0]    read_data;
    logic                          claimed;

    modport source (output valid, output read_data, output claimed, input ready);
    modport sink   (input valid, input read_data, input claimed, output ready);
endinterface

// ===== src/sem_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sem_ctrl.sv =====
// Controller: sequences each transaction through fetch and execute.
module sem_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sem_pkg::t_dp_status   i_status,
    output logic                  o_in_ready,
    output sem_pkg::t_ctrl_cmd    o_cmd
);

    sem_pkg::t_state r_state;
    sem_pkg::t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            sem_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = sem_pkg::ST_FETCH;
                end
            end
            sem_pkg::ST_FETCH: begin
                o_cmd.rd_en = 1'b1;
                n_state     = sem_pkg::ST_EXEC;
            end
            sem_pkg::ST_EXEC: begin
                // hold until the result register can take the result
                if (i_status.slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = sem_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sem_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sem_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/sem_dp.sv =====
// Datapath: bus decode, serial sequencer registers, word store and result register.
module sem_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sem_pkg::t_ctrl_cmd            i_cmd,
    output sem_pkg::t_dp_status           o_status,
    input  logic                          i_kind,
    input  logic [sem_pkg::ADDR_W-1:0]    i_address,
    input  logic [sem_pkg::DATA_W-1:0]    i_write_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [sem_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_claimed
);

    // latched transaction
    logic                          r_kind;
    logic [sem_pkg::ADDR_W-1:0]    r_addr;
    logic [sem_pkg::DATA_W-1:0]    r_wdata;

    // architectural state
    logic [sem_pkg::LINE_W-1:0]    r_line, n_line;
    logic                          r_enabled, n_enabled;
    logic                          r_wp, n_wp;
    sem_pkg::t_phase               r_phase, n_phase;
    logic [sem_pkg::CMD_W-1:0]     r_command, n_command;
    logic [sem_pkg::CNT_W-1:0]     r_bit_count, n_bit_count;
    logic [sem_pkg::WORD_W-1:0]    r_shift, n_shift;
    // words not written since the last bulk fill read as r_fill
    logic [sem_pkg::WORDS-1:0]     r_valid, n_valid;
    logic [sem_pkg::WORD_W-1:0]    r_fill, n_fill;

    // result register
    logic                          r_out_valid;
    logic [sem_pkg::DATA_W-1:0]    r_rd;
    logic                          r_claimed;

    // store access
    logic                          ram_we;
    logic [sem_pkg::WORD_AW-1:0]   ram_waddr;
    logic [sem_pkg::WORD_W-1:0]    ram_wdata;
    logic [sem_pkg::WORD_AW-1:0]   rd_idx;
    logic [sem_pkg::WORD_W-1:0]    ram_rdata;
    logic [sem_pkg::WORD_W-1:0]    word;

    // decode
    logic                          is_status, is_ctrl, is_direct;
    logic [sem_pkg::ADDR_W-1:0]    off;
    logic [2:0]                    lines;
    logic                          din;
    logic [sem_pkg::CMD_W-1:0]     cmd_shift;
    logic [sem_pkg::CNT_W-1:0]     cnt_inc;
    logic [3:0]                    pos;
    logic [sem_pkg::WORD_W-1:0]    shift_next;
    logic [sem_pkg::DATA_W-1:0]    rd;
    logic                          clm;

    assign is_status = (r_addr == sem_pkg::ADDR_STATUS);
    assign is_ctrl   = (r_addr == sem_pkg::ADDR_CTRL);
    assign is_direct = (r_addr >= sem_pkg::ADDR_DIRECT_LO) && (r_addr < sem_pkg::ADDR_DIRECT_HI);
    assign off       = r_addr - sem_pkg::ADDR_DIRECT_LO;
    assign rd_idx    = is_direct ? off[sem_pkg::WORD_AW:1]
                                 : r_command[sem_pkg::WORD_AW-1:0];
    assign word      = r_valid[rd_idx] ? ram_rdata : r_fill;

    assign lines      = r_wdata[2:0];
    assign din        = r_wdata[sem_pkg::LN_DI];
    assign cmd_shift  = {r_command[sem_pkg::CMD_W-2:0], din};
    assign cnt_inc    = r_bit_count + 5'd1;
    assign pos        = r_bit_count[3:0];
    assign shift_next = {r_shift[sem_pkg::WORD_W-2:0], din};

    sem_ram #(
        .WIDTH (sem_pkg::WORD_W),
        .DEPTH (sem_pkg::WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_line      = r_line;
        n_enabled   = r_enabled;
        n_wp        = r_wp;
        n_phase     = r_phase;
        n_command   = r_command;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_valid     = r_valid;
        n_fill      = r_fill;
        ram_we      = 1'b0;
        ram_waddr   = rd_idx;
        ram_wdata   = word;
        rd          = '0;
        clm         = 1'b0;

        if (!r_kind) begin
            if (r_enabled) begin
                if (is_status) begin
                    rd  = {5'd0, r_line[sem_pkg::LN_CS], 1'b1, r_line[sem_pkg::LN_DO]};
                    clm = 1'b1;
                end else if (is_direct) begin
                    rd  = off[0] ? word[15:8] : word[7:0];
                    clm = 1'b1;
                end
            end
        end else if (is_status) begin
            clm = 1'b1;
            if (!lines[sem_pkg::LN_CS]) begin
                // chip deselected: drop the sequence, DO floats high
                if (r_line[sem_pkg::LN_CS]) begin
                    n_phase     = sem_pkg::PH_START;
                    n_command   = '0;
                    n_bit_count = '0;
                end
                n_line = {1'b1, lines};
            end else if (lines[sem_pkg::LN_CLK] && !r_line[sem_pkg::LN_CLK]) begin
                n_line = {r_line[sem_pkg::LN_DO], lines};
                case (r_phase)
                    sem_pkg::PH_START: begin
                        if (din) begin
                            n_phase     = sem_pkg::PH_OPCODE;
                            n_command   = '0;
                            n_bit_count = '0;
                        end
                    end
                    sem_pkg::PH_OPCODE: begin
                        // a rejected erase stalls here until CS falls
                        if (r_bit_count < sem_pkg::OPC_BITS) begin
                            n_command   = cmd_shift;
                            n_bit_count = cnt_inc;
                            if (cnt_inc == sem_pkg::OPC_BITS) begin
                                case (cmd_shift[7:6])
                                    sem_pkg::OPC_EXT: begin
                                        case (cmd_shift[5:4])
                                            sem_pkg::EXT_EWDS: begin
                                                n_wp    = 1'b1;
                                                n_phase = sem_pkg::PH_START;
                                            end
                                            sem_pkg::EXT_WRAL: begin
                                                n_bit_count = '0;
                                                n_shift     = '0;
                                                n_phase     = sem_pkg::PH_WRITE;
                                            end
                                            sem_pkg::EXT_ERAL: begin
                                                if (!r_wp) begin
                                                    n_valid = '0;
                                                    n_fill  = sem_pkg::ERASED_WORD;
                                                end
                                                n_line[sem_pkg::LN_DO] = 1'b1;
                                                n_phase = sem_pkg::PH_START;
                                            end
                                            default: begin
                                                n_wp    = 1'b0;
                                                n_phase = sem_pkg::PH_START;
                                            end
                                        endcase
                                    end
                                    sem_pkg::OPC_WRITE: begin
                                        n_bit_count = '0;
                                        n_shift     = '0;
                                        n_phase     = sem_pkg::PH_WRITE;
                                    end
                                    sem_pkg::OPC_READ: begin
                                        n_bit_count = '0;
                                        n_phase     = sem_pkg::PH_READ;
                                        n_line[sem_pkg::LN_DO] = 1'b0;
                                    end
                                    default: begin
                                        if (!r_wp) begin
                                            ram_we    = 1'b1;
                                            ram_waddr = cmd_shift[sem_pkg::WORD_AW-1:0];
                                            ram_wdata = sem_pkg::ERASED_WORD;
                                            n_valid[cmd_shift[sem_pkg::WORD_AW-1:0]] = 1'b1;
                                            n_line[sem_pkg::LN_DO] = 1'b1;
                                            n_phase = sem_pkg::PH_START;
                                        end
                                    end
                                endcase
                            end
                        end
                    end
                    sem_pkg::PH_READ: begin
                        n_line[sem_pkg::LN_DO] = word[4'd15 - pos];
                        n_bit_count = {1'b0, pos} + 5'd1;
                        if (pos == 4'd15) begin
                            // advance to the next word
                            n_bit_count = '0;
                            n_command   = {sem_pkg::OPC_READ,
                                           r_command[sem_pkg::WORD_AW-1:0] + 6'd1};
                        end
                    end
                    sem_pkg::PH_WRITE: begin
                        n_shift     = shift_next;
                        n_bit_count = {1'b0, pos} + 5'd1;
                        if (pos == 4'd15) begin
                            if (!r_wp) begin
                                if (r_command[6]) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_command[sem_pkg::WORD_AW-1:0];
                                    ram_wdata = shift_next;
                                    n_valid[r_command[sem_pkg::WORD_AW-1:0]] = 1'b1;
                                end else begin
                                    n_valid = '0;
                                    n_fill  = shift_next;
                                end
                            end
                            n_bit_count = '0;
                            n_line[sem_pkg::LN_DO] = 1'b1;
                            n_phase = sem_pkg::PH_START;
                        end
                    end
                    default: begin
                        n_phase = sem_pkg::PH_START;
                    end
                endcase
            end else begin
                n_line = {r_line[sem_pkg::LN_DO], lines};
            end
        end else if (is_ctrl) begin
            clm = 1'b1;
            if (r_wdata[sem_pkg::CTRL_INIT_BIT]) begin
                n_enabled   = 1'b0;
                n_line      = sem_pkg::LINE_RESET;
                n_wp        = 1'b1;
                n_phase     = sem_pkg::PH_START;
                n_command   = '0;
                n_bit_count = '0;
            end else begin
                n_enabled = r_wdata[sem_pkg::CTRL_EN_BIT];
            end
        end else if (is_direct) begin
            clm       = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = rd_idx;
            ram_wdata = off[0] ? {r_wdata, word[7:0]} : {word[15:8], r_wdata};
            n_valid[rd_idx] = 1'b1;
        end

        // only a committed transaction writes the store
        if (!i_cmd.commit) begin
            ram_we = 1'b0;
        end
    end

    assign o_status.slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (i_cmd.commit) begin
            r_rd      <= rd;
            r_claimed <= clm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= sem_pkg::LINE_RESET;
            r_enabled   <= 1'b0;
            r_wp        <= 1'b1;
            r_phase     <= sem_pkg::PH_START;
            r_command   <= '0;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_valid     <= '0;
            r_fill      <= sem_pkg::ERASED_WORD;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_line      <= n_line;
                r_enabled   <= n_enabled;
                r_wp        <= n_wp;
                r_phase     <= n_phase;
                r_command   <= n_command;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_valid     <= n_valid;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rd;
    assign o_claimed   = r_claimed;

endmodule

// ===== src/serial_eeprom_microwire_port.sv =====
// Top level of the serial EEPROM port: controller, datapath and channel wiring.
//
// A 64 x 16-bit Microwire EEPROM (93C46 style) seen through CPU bus accesses. Each
// transaction on the input channel is one bus read or write and yields exactly one
// result (read byte and claim flag). Address 0x8000 drives the serial lines on a
// write (DI bit0, CLK bit1, CS bit2) and returns status on a read (CS bit2, one in
// bit1, DO bit0); 0xFFFC is the control register (bit7 reinitializes the port,
// otherwise bit3 sets the enable); 0x8008-0x8087 give direct byte access to the
// words. Reads are claimed only while the port is enabled. After acceptance the
// controller fetches the word with a registered read of the word store, then
// executes and loads the result register. A new transaction is accepted only
// after the previous one commits; a full result register holds execution until it
// drains. Bulk erase and write-all need no per-word pass: words not written
// since the last bulk fill read as the fill value. The store needs no clearing
// pass after reset.
module serial_eeprom_microwire_port (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sem_in_if.sink     i_in,
    sem_out_if.source  o_out
);

    sem_pkg::t_ctrl_cmd  cmd;
    sem_pkg::t_dp_status status;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    sem_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_in.kind),
        .i_address    (i_in.address),
        .i_write_data (i_in.write_data),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_read_data  (o_out.read_data),
        .o_claimed    (o_out.claimed)
    );

endmodule
